/* rtl/hpti_pkg.sv */
package hpti_pkg;

  // Number of hash groups in the table and the width of a group index.
  localparam int unsigned GROUPS  = 1024;
  localparam int unsigned GROUP_W = $clog2(GROUPS);
  localparam int unsigned SLOTS   = 8;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);

  // Depth of the two small queues: front to back, and back to the result port.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Fixed fields of a new entry.
  localparam logic [11:0] LOWER_LOW_BITS = 12'h002;  // R, C, WIMG clear, PP read-write
  localparam logic        HASH_PRIMARY   = 1'b0;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic [31:0] virt_addr;
    logic [23:0] segment_id;
  } in_item_t;

  typedef struct packed {
    logic               placed;
    logic [GROUP_W-1:0] group_index;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        entry_upper;
    logic [31:0]        entry_lower;
  } out_item_t;

  // A classified request waiting for the back end.
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [31:0]        upper;
    logic [31:0]        lower;
  } work_item_t;

  // Back end to front end control.
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_ctl_t;

endpackage

/* rtl/hpti_front.sv */
module hpti_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  hpti_pkg::in_item_t          in_data,
  input  logic [hpti_pkg::GROUP_W-1:0] hash_mask,
  input  hpti_pkg::back_ctl_t         back_ctl,
  output logic                        wq_valid,
  output hpti_pkg::work_item_t        wq_item
);

  hpti_pkg::work_item_t                q_r [hpti_pkg::QDEPTH];
  logic                                wptr_r, wptr_nxt;
  logic                                rptr_r, rptr_nxt;
  logic [hpti_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                push;
  logic                                pop;
  logic [18:0]                         hash;
  hpti_pkg::work_item_t                cls;

  // Primary hash of the request and the entry words it would produce.
  always_comb begin
    hash      = in_data.segment_id[18:0] ^ {3'b000, in_data.virt_addr[27:12]};
    cls.group = hash[hpti_pkg::GROUP_W-1:0] & hash_mask;
    cls.upper = {1'b1, in_data.segment_id, hpti_pkg::HASH_PRIMARY, in_data.virt_addr[27:22]};
    cls.lower = {in_data.phys_addr[31:12], hpti_pkg::LOWER_LOW_BITS};
  end

  assign in_full  = back_ctl.clearing ||
                    (cnt_r == hpti_pkg::QCNT_W'(hpti_pkg::QDEPTH));
  assign push     = in_push && !in_full;
  assign pop      = back_ctl.pop;
  assign wq_valid = (cnt_r != '0);
  assign wq_item  = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + hpti_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - hpti_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

/* rtl/hpti_back.sv */
module hpti_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wq_valid,
  input  hpti_pkg::work_item_t  wq_item,
  output hpti_pkg::back_ctl_t   back_ctl,
  output logic                  out_empty,
  input  logic                  out_pop,
  output hpti_pkg::out_item_t   out_data
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [hpti_pkg::GROUP_W-1:0]        clr_r, clr_nxt;
  hpti_pkg::work_item_t                cur_r, cur_nxt;

  // Valid bits only: one row of eight per group.
  logic [hpti_pkg::SLOTS-1:0]          vmem [hpti_pkg::GROUPS];
  logic [hpti_pkg::SLOTS-1:0]          rd_data_r;
  logic                                rd_en;
  logic                                wr_en;
  logic [hpti_pkg::GROUP_W-1:0]        wr_addr;
  logic [hpti_pkg::SLOTS-1:0]          wr_data;

  logic                                found;
  logic [hpti_pkg::SLOT_W-1:0]         free_slot;
  logic [hpti_pkg::SLOTS-1:0]          slot_bit;
  hpti_pkg::out_item_t                 res;

  hpti_pkg::out_item_t                 rq_r [hpti_pkg::QDEPTH];
  logic                                rq_wptr_r, rq_rptr_r;
  logic [hpti_pkg::QCNT_W-1:0]         rq_cnt_r, rq_cnt_nxt;
  logic                                rq_push;
  logic                                rq_pop;

  // First free slot of the row that was read.
  always_comb begin
    found     = 1'b0;
    free_slot = '0;
    for (int i = hpti_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!rd_data_r[i]) begin
        found     = 1'b1;
        free_slot = hpti_pkg::SLOT_W'(i);
      end
    end
    slot_bit = found ? (hpti_pkg::SLOTS'(1) << free_slot) : '0;
  end

  always_comb begin
    res.placed      = found;
    res.group_index = cur_r.group;
    res.slot        = free_slot;
    res.entry_upper = cur_r.upper;
    res.entry_lower = cur_r.lower;
  end

  always_comb begin
    state_nxt         = state_r;
    clr_nxt           = clr_r;
    cur_nxt           = cur_r;
    rd_en             = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = cur_r.group;
    wr_data           = rd_data_r | slot_bit;
    rq_push           = 1'b0;
    back_ctl.pop      = 1'b0;
    back_ctl.clearing = (state_r == ST_CLEAR);
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + hpti_pkg::GROUP_W'(1);
        if (clr_r == hpti_pkg::GROUP_W'(hpti_pkg::GROUPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (wq_valid && (rq_cnt_r != hpti_pkg::QCNT_W'(hpti_pkg::QDEPTH))) begin
          rd_en        = 1'b1;
          back_ctl.pop = 1'b1;
          cur_nxt      = wq_item;
          state_nxt    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        wr_en     = found;
        rq_push   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vmem[wq_item.group];
    end
  end

  // Result queue.
  assign rq_pop    = out_pop && !out_empty;
  assign out_empty = (rq_cnt_r == '0);
  assign out_data  = rq_r[rq_rptr_r];

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + hpti_pkg::QCNT_W'(1);
    end else if (rq_pop && !rq_push) begin
      rq_cnt_nxt = rq_cnt_r - hpti_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wptr_r <= 1'b0;
      rq_rptr_r <= 1'b0;
      rq_cnt_r  <= '0;
    end else begin
      if (rq_push) begin
        rq_wptr_r <= ~rq_wptr_r;
      end
      if (rq_pop) begin
        rq_rptr_r <= ~rq_rptr_r;
      end
      rq_cnt_r <= rq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_r[rq_wptr_r] <= res;
    end
  end

endmodule

/* rtl/hashed_page_table_insert_core.sv */
// Each request passes the front queue and the back end; then its result shows (out_empty low).
// The back end takes one request at a time: it reads the group's valid row, then writes it back.
// Reset: synchronous, active low; hash_mask returns to 1023 and the queues empty.
// After reset a clearing pass writes all 1024 valid rows, one per cycle, holding in_full high.
// Configuration writes are taken at any time, including during the clearing pass.
module hashed_page_table_insert_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  hpti_pkg::in_item_t            in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output hpti_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hpti_pkg::GROUP_W-1:0]  cfg_data
);

  // The hash mask register. A new value only matters for requests that
  // transfer after it is written, since the front end applies it at intake.
  logic [hpti_pkg::GROUP_W-1:0] hash_mask_r;

  hpti_pkg::back_ctl_t          back_ctl;
  logic                         wq_valid;
  hpti_pkg::work_item_t         wq_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mask_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      hash_mask_r <= cfg_data;
    end
  end

  // The front end hashes each request, forms the two entry words and
  // queues the work. It stalls the input only when its queue is full or
  // while the table is being cleared.
  hpti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .hash_mask (hash_mask_r),
    .back_ctl  (back_ctl),
    .wq_valid  (wq_valid),
    .wq_item   (wq_item)
  );

  // The back end owns the table. Only the valid bits influence any result,
  // so each group is kept as one 8-bit row of valid bits. A request reads
  // its row, then in the following cycle finds the first free slot, writes
  // the row back with that bit set if a slot was free and queues the result.
  hpti_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wq_valid  (wq_valid),
    .wq_item   (wq_item),
    .back_ctl  (back_ctl),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* tb/hashed_page_table_insert_core_tb.sv */
module hashed_page_table_insert_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The clearing pass after reset holds in_full high while it clears every valid row.
  // That is the longest stretch in a correct run with no transfer on any port.
  // The limit sits several times above it.
  localparam int unsigned STALL_LIMIT  = 6000;
  // Extra cycles that cover anything still in flight once every expected result
  // has come back.
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned NUM_PHASES   = 8;

  // A directed row: one request and, where it is obvious, the result it must give.
  typedef struct packed {
    hpti_pkg::in_item_t  req;
    logic                typed;
    hpti_pkg::out_item_t want;
  } dir_row_t;

  localparam hpti_pkg::out_item_t NO_WANT = '0;
  localparam int unsigned NUM_DIR = 17;

  // Table rows run with hash_mask at its reset value of 1023.
  // The first two rows land in group 0. The six rows after them map the same
  // page again and fill the group. Rows that follow and hash to group 0 find
  // the group full.
  localparam dir_row_t DIRECTED [NUM_DIR] = '{
    // All fields zero: group 0, slot 0.
    '{'{32'h0000_0000, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd0, 32'h8000_0000, 32'h0000_0002}},
    // All fields ones. The low ten hash bits cancel out, so this goes to group 0, slot 1.
    '{'{32'hffff_ffff, 32'hffff_ffff, 24'hffffff}, 1'b1,
      '{1'b1, 10'd0, 3'd1, 32'hffff_ffbf, 32'hffff_f002}},
    // The same page is mapped again and again. No duplicate is detected.
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd2, 32'h8000_0000, 32'h1234_5002}},
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd3, 32'h8000_0000, 32'h1234_5002}},
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd4, 32'h8000_0000, 32'h1234_5002}},
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd5, 32'h8000_0000, 32'h1234_5002}},
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd6, 32'h8000_0000, 32'h1234_5002}},
    '{'{32'h1234_5678, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b1, 10'd0, 3'd7, 32'h8000_0000, 32'h1234_5002}},
    // Group 0 is now full. Nothing is placed, but the entry words still show.
    '{'{32'habcd_e123, 32'h0000_0000, 24'h000000}, 1'b1,
      '{1'b0, 10'd0, 3'd0, 32'h8000_0000, 32'habcd_e002}},
    // The top nibble of the virtual address takes no part in the hash or the API.
    '{'{32'h0000_0000, 32'hf000_0000, 24'h000000}, 1'b1,
      '{1'b0, 10'd0, 3'd0, 32'h8000_0000, 32'h0000_0002}},
    // The top five bits of the segment ID take no part in the hash.
    '{'{32'h0000_0fff, 32'h0000_0000, 24'hf80000}, 1'b1,
      '{1'b0, 10'd0, 3'd0, 32'hfc00_0000, 32'h0000_0002}},
    // The segment ID and the page index cancel in the XOR.
    '{'{32'h0000_1fff, 32'h0000_3000, 24'h000003}, 1'b1,
      '{1'b0, 10'd0, 3'd0, 32'h8000_0180, 32'h0000_1002}},
    // The hash is wider than the table, so the group index wraps.
    '{'{32'h0000_0000, 32'h0000_0000, 24'h07fc05}, 1'b0, NO_WANT},
    '{'{32'h5555_5555, 32'h0fff_f000, 24'h000000}, 1'b0, NO_WANT},
    '{'{32'h0000_0000, 32'h0fc0_0000, 24'h000aaa}, 1'b0, NO_WANT},
    '{'{32'haaaa_aaaa, 32'h5555_5555, 24'h555555}, 1'b0, NO_WANT},
    '{'{32'h8000_0000, 32'h0000_0000, 24'hffffff}, 1'b0, NO_WANT}
  };

  // One value of hash_mask for each random phase, with both extremes among them.
  localparam logic [hpti_pkg::GROUP_W-1:0] PHASE_MASK [NUM_PHASES] = '{
    10'd1023, 10'd0, 10'd7, 10'd1023, 10'd63, 10'd1, 10'd511, 10'd1023
  };

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_push   = 1'b0;
  logic                         in_full;
  hpti_pkg::in_item_t           in_data   = '0;
  logic                         out_empty;
  logic                         out_pop   = 1'b0;
  hpti_pkg::out_item_t          out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [hpti_pkg::GROUP_W-1:0] cfg_data  = '0;

  hashed_page_table_insert_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Our own copy of the table. The valid bits are all that decide a placement,
  // so each group keeps one valid bit per slot. The copy of hash_mask follows
  // every configuration transfer.
  logic [hpti_pkg::SLOTS-1:0]   slot_valid [hpti_pkg::GROUPS];
  logic [hpti_pkg::GROUP_W-1:0] group_mask;
  hpti_pkg::out_item_t          pending_results [$];
  int unsigned                  mismatches;

  // Insert one request into the shadow table and return the result the block
  // must give. The hash is (segment ID low 19 bits XOR page index low 16 bits),
  // masked with hash_mask. Only the low GROUP_W bits survive, which is the same
  // as the wrap to the table size.
  function automatic hpti_pkg::out_item_t insert_mapping(hpti_pkg::in_item_t req);
    logic [18:0]                  hash;
    logic [hpti_pkg::GROUP_W-1:0] grp;
    hpti_pkg::out_item_t          res;
    hash = req.segment_id[18:0] ^ {3'b000, req.virt_addr[27:12]};
    grp  = hash[hpti_pkg::GROUP_W-1:0] & group_mask;
    res.placed      = 1'b0;
    res.group_index = grp;
    res.slot        = '0;
    res.entry_upper = {1'b1, req.segment_id, hpti_pkg::HASH_PRIMARY, req.virt_addr[27:22]};
    res.entry_lower = {req.phys_addr[31:12], hpti_pkg::LOWER_LOW_BITS};
    for (int s = 0; s < hpti_pkg::SLOTS; s++) begin
      if (!res.placed && !slot_valid[grp][s]) begin
        slot_valid[grp][s] = 1'b1;
        res.placed = 1'b1;
        res.slot   = hpti_pkg::SLOT_W'(s);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  // Result side. Each transfer is compared with the oldest expected result.
  always @(posedge clk) begin
    hpti_pkg::out_item_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0h with nothing expected", out_data));
      end else begin
        want = pending_results.pop_front();
        check_field("placed", 32'(out_data.placed), 32'(want.placed));
        check_field("group_index", 32'(out_data.group_index), 32'(want.group_index));
        check_field("slot", 32'(out_data.slot), 32'(want.slot));
        check_field("entry_upper", out_data.entry_upper, want.entry_upper);
        check_field("entry_lower", out_data.entry_lower, want.entry_lower);
      end
    end
  end

  // Watchdog: count the cycles in which no transfer happens on any port.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It moves between several pop patterns, each for a random number of
  // cycles: always ready, coin flip, long stalls, and one pop in three.
  initial begin
    int unsigned mode;
    int unsigned span;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0: begin
            out_pop <= 1'b1;
          end
          1: begin
            out_pop <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_pop <= ($urandom_range(0, 15) == 0);
          end
          default: begin
            out_pop <= (c % 3 == 0);
          end
        endcase
      end
    end
  end

  // Offer one request starting at a falling edge and hold it until its transfer.
  // Push stays high on return, so a burst goes on without a gap. The expected
  // result is queued at the edge of the transfer. A directed row with a typed
  // result still goes through the shadow table so that the table stays current.
  task automatic send_request(hpti_pkg::in_item_t req, logic typed,
                              hpti_pkg::out_item_t want);
    hpti_pkg::out_item_t model_res;
    in_data <= req;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    model_res = insert_mapping(req);
    pending_results.push_back(typed ? want : model_res);
    @(negedge clk);
  endtask

  task automatic idle_input(int unsigned cycles);
    in_push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop offering requests until every expected result has come back, then let
  // anything still in flight drain out.
  task automatic drain_results();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_mask(logic [hpti_pkg::GROUP_W-1:0] mask);
    cfg_data  <= mask;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    group_mask = mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build a random request. About a third reuse a recent key, so that groups
  // fill up and the same page gets mapped twice even with a wide mask. In that
  // case the bits outside the hash are still fresh.
  function automatic hpti_pkg::in_item_t random_request(
      ref hpti_pkg::in_item_t recent_keys [$]);
    hpti_pkg::in_item_t req;
    req.phys_addr  = $urandom();
    req.virt_addr  = $urandom();
    req.segment_id = 24'($urandom());
    if (recent_keys.size() != 0 && $urandom_range(0, 2) == 0) begin
      int unsigned k;
      k = $urandom_range(0, recent_keys.size() - 1);
      req.virt_addr[27:12] = recent_keys[k].virt_addr[27:12];
      req.segment_id[18:0] = recent_keys[k].segment_id[18:0];
    end
    recent_keys.push_back(req);
    if (recent_keys.size() > 16) begin
      void'(recent_keys.pop_front());
    end
    return req;
  endfunction

  initial begin
    hpti_pkg::in_item_t recent_keys [$];
    int unsigned        sent;
    int unsigned        burst;

    for (int g = 0; g < hpti_pkg::GROUPS; g++) begin
      slot_valid[g] = '0;
    end
    group_mask = 10'd1023;
    mismatches = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Requests are offered during the clearing pass, and the
    // block must hold them off until the pass is done.
    for (int r = 0; r < NUM_DIR; r++) begin
      send_request(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want);
      if ($urandom_range(0, 3) == 0) begin
        idle_input($urandom_range(1, 5));
      end
    end

    // Random phases. Each one starts from an idle block with a new mask.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_mask(PHASE_MASK[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          send_request(random_request(recent_keys), 1'b0, NO_WANT);
          sent++;
        end
        if ($urandom_range(0, 30) == 0) begin
          drain_results();
        end else if ($urandom_range(0, 3) != 0) begin
          idle_input($urandom_range(1, 8));
        end
      end
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* hashed_page_table_insert_core.f */
rtl/hpti_pkg.sv
rtl/hpti_front.sv
rtl/hpti_back.sv
rtl/hashed_page_table_insert_core.sv
tb/hashed_page_table_insert_core_tb.sv
